// ===== rtl/ifp_pkg.sv =====
// Shared types, frame codes and scale constants for the IMU frame parser.
package ifp_pkg;

   // Frame layout.
   localparam logic [3:0] FRAME_LAST   = 4'd10;
   localparam logic [7:0] HEADER_RESET = 8'h5A;

   // Type byte codes.
   localparam logic [7:0] TYPE_RATE   = 8'hAA;
   localparam logic [7:0] TYPE_ANGLE  = 8'hBB;
   localparam logic [7:0] TYPE_ACCEL  = 8'hCC;
   localparam logic [7:0] TYPE_QUAT   = 8'hDD;
   localparam logic [7:0] TYPE_REPORT = 8'hEE;

   // Scale factors that bring the raw 16-bit readings to Q16.16 values.
   localparam logic signed [13:0] SCALE_RATE  = 14'sd4000;
   localparam logic signed [13:0] SCALE_ANGLE = 14'sd360;
   localparam logic signed [13:0] SCALE_ACCEL = 14'sd3136;
   localparam logic signed [13:0] SCALE_QUAT  = 14'sd2;

   // Reciprocal of ten for a 27-bit magnitude: q = (m * RECIP) >> 35.
   localparam logic [31:0] DIV10_RECIP = 32'hCCCCCCCD;

   typedef enum logic [2:0] {
      ST_RATE     = 3'd0,
      ST_ANGLE    = 3'd1,
      ST_ACCEL    = 3'd2,
      ST_QUAT     = 3'd3,
      ST_REPORT   = 3'd4,
      ST_CSUM_ERR = 3'd5,
      ST_UNKNOWN  = 3'd6
   } status_type;

   // Per-request information passed from the frame control to the scaler.
   typedef struct packed {
      logic              take;    // a request is accepted this cycle
      logic [3:0]        idx;     // position of the byte in the frame
      logic signed [15:0] raw;    // this byte as high half over the stored low byte
      status_type        kind;    // frame kind decoded from the type byte
      logic              done;    // this request closes a frame with a result
      status_type        status;  // final status of the closing frame
   } step_type;

   function automatic status_type decode_type(input logic [7:0] code);
      status_type s;
      unique case (code)
         TYPE_RATE:   s = ST_RATE;
         TYPE_ANGLE:  s = ST_ANGLE;
         TYPE_ACCEL:  s = ST_ACCEL;
         TYPE_QUAT:   s = ST_QUAT;
         TYPE_REPORT: s = ST_REPORT;
         default:     s = ST_UNKNOWN;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/imu_frame_parser.sv =====
// Top level of the IMU serial frame parser with its result register.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_rx_byte
//   rsp      out        rsp_valid / rsp_stall  rsp_frame_status, rsp_value_a..d
//   csr      in         csr_wr_en              csr_wr_data (header byte)
//
// One request is accepted per cycle unless the input stalls; a frame's result
// is loaded into the result register when its eleventh byte is taken. Readings
// a-c are multiplied at their high byte and stored on the next, divided by ten
// for accel; reading d is doubled at its high byte. Reset clears the byte count
// and the result valid and sets the header to 0x5A. The input stalls only on the
// closing byte of a frame while an earlier result is still held and stalled.
module imu_frame_parser
   import ifp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_frame_status,
   output logic signed [27:0] rsp_value_a,
   output logic signed [27:0] rsp_value_b,
   output logic signed [27:0] rsp_value_c,
   output logic signed [16:0] rsp_value_d,
   input  logic               csr_wr_en,
   input  logic [7:0]         csr_wr_data
);

   step_type           step;
   logic               take;
   logic               last_byte;
   logic signed [27:0] val_a, val_b, val_c;
   logic signed [16:0] val_d;
   logic               has_vals;

   logic               valid_ff, valid_in;
   logic [2:0]         status_ff, status_in;
   logic signed [27:0] a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic signed [16:0] d_ff, d_in;

   // Only a closing byte must wait for the result register.
   assign req_stall = valid_ff && rsp_stall && last_byte;
   assign take      = req_valid && !req_stall;

   ifp_frame_ctl u_ctl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .take        (take),
      .rx_byte     (req_rx_byte),
      .last_byte   (last_byte),
      .step        (step)
   );

   ifp_scaler u_scaler (
      .clock   (clock),
      .step    (step),
      .value_a (val_a),
      .value_b (val_b),
      .value_c (val_c),
      .value_d (val_d)
   );

   assign has_vals = (step.status == ST_RATE) || (step.status == ST_ANGLE) ||
                     (step.status == ST_ACCEL) || (step.status == ST_QUAT);

   // Load the result register at the end of a frame; drop valid once taken.
   always_comb begin
      valid_in  = valid_ff && rsp_stall;
      status_in = status_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      d_in      = d_ff;
      if (step.done) begin
         valid_in  = 1'b1;
         status_in = step.status;
         a_in      = has_vals ? val_a : '0;
         b_in      = has_vals ? val_b : '0;
         c_in      = has_vals ? val_c : '0;
         d_in      = (step.status == ST_QUAT) ? val_d : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      status_ff <= status_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      c_ff      <= c_in;
      d_ff      <= d_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_frame_status = status_ff;
   assign rsp_value_a      = a_ff;
   assign rsp_value_b      = b_ff;
   assign rsp_value_c      = c_ff;
   assign rsp_value_d      = d_ff;

endmodule

// ===== rtl/ifp_frame_ctl.sv =====
// Byte counter, header check, running checksum and frame status for the parser.
module ifp_frame_ctl
   import ifp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       take,
   input  logic [7:0] rx_byte,
   output logic       last_byte,
   output step_type   step
);

   logic [7:0] header_ff, header_in;
   logic [3:0] count_ff, count_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] type_ff, type_in;
   logic [7:0] low_ff, low_in;
   logic [7:0] sum_ff, sum_in;

   logic [3:0] idx;
   logic       hdr_ok;
   status_type kind;

   // Position of this byte; an out-of-range count restarts the frame.
   assign idx       = (count_ff > FRAME_LAST) ? 4'd0 : count_ff;
   assign last_byte = (count_ff == FRAME_LAST);

   // The opening byte is checked against the header on every request.
   assign hdr_ok = (idx == 4'd0) ? (rx_byte == header_ff) : (first_ff == header_ff);
   assign kind   = decode_type(type_ff);

   // Next values of the frame registers.
   always_comb begin
      header_in = csr_wr_en ? csr_wr_data : header_ff;
      count_in  = count_ff;
      first_in  = first_ff;
      type_in   = type_ff;
      low_in    = low_ff;
      sum_in    = sum_ff;
      if (take) begin
         if (!hdr_ok || idx == FRAME_LAST) begin
            count_in = 4'd0;
         end else begin
            count_in = idx + 4'd1;
         end
         if (idx == 4'd0) begin
            first_in = rx_byte;
            sum_in   = rx_byte;
         end else if (idx < FRAME_LAST) begin
            sum_in = sum_ff + rx_byte;
         end
         if (idx == 4'd1) begin
            type_in = rx_byte;
         end
         if (idx[0] == 1'b0 && idx != 4'd0 && idx < FRAME_LAST) begin
            low_in = rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HEADER_RESET;
         count_ff  <= 4'd0;
      end else begin
         header_ff <= header_in;
         count_ff  <= count_in;
      end
      first_ff <= first_in;
      type_ff  <= type_in;
      low_ff   <= low_in;
      sum_ff   <= sum_in;
   end

   // Status of a closing frame: unknown type wins over a checksum mismatch.
   always_comb begin
      step.take   = take;
      step.idx    = idx;
      step.raw    = $signed({rx_byte, low_ff});
      step.kind   = kind;
      step.done   = take && hdr_ok && (idx == FRAME_LAST);
      step.status = kind;
      if (kind != ST_UNKNOWN && sum_ff != rx_byte) begin
         step.status = ST_CSUM_ERR;
      end
   end

endmodule

// ===== rtl/ifp_scaler.sv =====
// Scales the raw readings of a frame into Q16.16 values as the bytes arrive.
module ifp_scaler
   import ifp_pkg::*;
(
   input  logic               clock,
   input  step_type           step,
   output logic signed [27:0] value_a,
   output logic signed [27:0] value_b,
   output logic signed [27:0] value_c,
   output logic signed [16:0] value_d
);

   logic signed [27:0] prod_ff, prod_in;
   logic signed [27:0] val_ff [3];
   logic signed [27:0] val_in [3];
   logic signed [16:0] vd_ff, vd_in;

   logic signed [13:0] scale;
   logic signed [29:0] prod_full;
   logic               neg;
   logic [26:0]        mag;
   logic [58:0]        recip_prod;
   logic [23:0]        quot_mag;
   logic signed [27:0] quot;
   logic signed [27:0] scaled;

   // Scale factor by frame kind; kinds without values take any factor.
   always_comb begin
      case (step.kind)
         ST_RATE:  scale = SCALE_RATE;
         ST_ANGLE: scale = SCALE_ANGLE;
         ST_ACCEL: scale = SCALE_ACCEL;
         default:  scale = SCALE_QUAT;
      endcase
   end

   assign prod_full = step.raw * scale;

   // Divide the held product by ten, truncating toward zero.
   assign neg        = prod_ff[27];
   assign mag        = neg ? 27'(-prod_ff) : prod_ff[26:0];
   assign recip_prod = 59'(mag) * 59'(DIV10_RECIP);
   assign quot_mag   = recip_prod[58:35];
   assign quot       = neg ? -$signed({4'b0000, quot_mag}) : $signed({4'b0000, quot_mag});
   assign scaled     = (step.kind == ST_ACCEL) ? quot : prod_ff;

   // High bytes at 3, 5 and 7 multiply; the byte after stores the scaled value.
   always_comb begin
      prod_in   = prod_ff;
      val_in[0] = val_ff[0];
      val_in[1] = val_ff[1];
      val_in[2] = val_ff[2];
      vd_in     = vd_ff;
      if (step.take) begin
         case (step.idx)
            4'd3, 4'd5, 4'd7: prod_in = prod_full[27:0];
            4'd4:             val_in[0] = scaled;
            4'd6:             val_in[1] = scaled;
            4'd8:             val_in[2] = scaled;
            4'd9:             vd_in = {step.raw, 1'b0};
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      val_ff[0] <= val_in[0];
      val_ff[1] <= val_in[1];
      val_ff[2] <= val_in[2];
      vd_ff     <= vd_in;
   end

   assign value_a = val_ff[0];
   assign value_b = val_ff[1];
   assign value_c = val_ff[2];
   assign value_d = vd_ff;

endmodule
